/* design/cawf_pkg.sv */
// Shared types and operation codes for the 8-bit CPU ALU with flags.
// Depends on nothing; used by cawf_alu and cpu_alu_with_flags_unit.
package cawf_pkg;

   // Operation codes
   localparam logic [4:0] OP_ADD   = 5'd0;
   localparam logic [4:0] OP_ADC   = 5'd1;
   localparam logic [4:0] OP_SUB   = 5'd2;
   localparam logic [4:0] OP_SBC   = 5'd3;
   localparam logic [4:0] OP_AND   = 5'd4;
   localparam logic [4:0] OP_XOR   = 5'd5;
   localparam logic [4:0] OP_OR    = 5'd6;
   localparam logic [4:0] OP_CP    = 5'd7;
   localparam logic [4:0] OP_INC   = 5'd8;
   localparam logic [4:0] OP_DEC   = 5'd9;
   localparam logic [4:0] OP_INC16 = 5'd10;
   localparam logic [4:0] OP_DEC16 = 5'd11;
   localparam logic [4:0] OP_ADDHL = 5'd12;
   localparam logic [4:0] OP_ADDSP = 5'd13;
   localparam logic [4:0] OP_DAA   = 5'd14;
   localparam logic [4:0] OP_CPL   = 5'd15;
   localparam logic [4:0] OP_SCF   = 5'd16;
   localparam logic [4:0] OP_CCF   = 5'd17;
   localparam logic [4:0] OP_RLC   = 5'd18;
   localparam logic [4:0] OP_RRC   = 5'd19;
   localparam logic [4:0] OP_RL    = 5'd20;
   localparam logic [4:0] OP_RR    = 5'd21;
   localparam logic [4:0] OP_SLA   = 5'd22;
   localparam logic [4:0] OP_SRA   = 5'd23;
   localparam logic [4:0] OP_SRL   = 5'd24;
   localparam logic [4:0] OP_SWAP  = 5'd25;
   localparam logic [4:0] OP_BIT   = 5'd26;
   localparam logic [4:0] OP_RES   = 5'd27;
   localparam logic [4:0] OP_SET   = 5'd28;

   // Decimal adjust corrections
   localparam logic [7:0] DAA_HIGH = 8'h60;
   localparam logic [7:0] DAA_LOW  = 8'h06;
   localparam logic [7:0] BCD_MAX  = 8'h99;
   localparam logic [3:0] DIGIT_MAX = 4'd9;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [4:0]  opcode;
      logic [7:0]  acc_value;
      logic [7:0]  operand_byte;
      logic [2:0]  bit_index;
      logic [15:0] wide_left;
      logic [15:0] wide_right;
   } req_type;

   typedef struct packed {
      logic [7:0]  result_byte;
      logic [15:0] result_word;
      logic        flag_z;
      logic        flag_n;
      logic        flag_h;
      logic        flag_c;
   } rsp_type;

endpackage

/* design/cawf_alu.sv */
// Combinational ALU datapath: one request plus the current flags in,
// one response and the next flags out. Depends on cawf_pkg.
module cawf_alu (
   input  cawf_pkg::req_type   req,
   input  cawf_pkg::flags_type flags,
   output cawf_pkg::rsp_type   rsp,
   output cawf_pkg::flags_type flags_next
);
   import cawf_pkg::*;

   always_comb begin
      logic [7:0]  a;
      logic [7:0]  b;
      logic        cin;
      logic [8:0]  sum9;
      logic [4:0]  nib5;
      logic [16:0] sum17;
      logic [12:0] sum13;
      logic [7:0]  corr;
      logic [7:0]  mask;
      logic [7:0]  r;
      logic [15:0] w;
      flags_type   f;

      a    = req.acc_value;
      b    = req.operand_byte;
      cin  = 1'b0;
      sum9 = '0;
      nib5 = '0;
      sum17 = '0;
      sum13 = '0;
      corr = '0;
      mask = 8'd1 << req.bit_index;
      r    = a;
      w    = '0;
      f    = flags;

      unique case (req.opcode) inside
         OP_ADD, OP_ADC: begin
            cin  = (req.opcode == OP_ADC) ? flags.c : 1'b0;
            sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
            nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
            r    = sum9[7:0];
            f    = '{z: (r == 8'd0), n: 1'b0, h: nib5[4], c: sum9[8]};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            cin  = (req.opcode == OP_SBC) ? flags.c : 1'b0;
            sum9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
            nib5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
            f    = '{z: (sum9[7:0] == 8'd0), n: 1'b1, h: nib5[4], c: sum9[8]};
            r    = (req.opcode == OP_CP) ? a : sum9[7:0];
         end
         OP_AND: begin
            r = a & b;
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
         end
         OP_XOR: begin
            r = a ^ b;
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_OR: begin
            r = a | b;
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_INC: begin
            r = a + 8'd1;
            f = '{z: (r == 8'd0), n: 1'b0, h: (a[3:0] == 4'hF), c: flags.c};
         end
         OP_DEC: begin
            r = a - 8'd1;
            f = '{z: (r == 8'd0), n: 1'b1, h: (a[3:0] == 4'h0), c: flags.c};
         end
         OP_INC16: w = req.wide_left + 16'd1;
         OP_DEC16: w = req.wide_left - 16'd1;
         OP_ADDHL: begin
            sum17 = {1'b0, req.wide_left} + {1'b0, req.wide_right};
            sum13 = {1'b0, req.wide_left[11:0]} + {1'b0, req.wide_right[11:0]};
            w     = sum17[15:0];
            f     = '{z: flags.z, n: 1'b0, h: sum13[12], c: sum17[16]};
         end
         OP_ADDSP: begin
            w    = req.wide_left + {{8{b[7]}}, b};
            sum9 = {1'b0, req.wide_left[7:0]} + {1'b0, b};
            nib5 = {1'b0, req.wide_left[3:0]} + {1'b0, b[3:0]};
            f    = '{z: 1'b0, n: 1'b0, h: nib5[4], c: sum9[8]};
         end
         OP_DAA: begin
            if (!flags.n) begin
               // After an add: decide both corrections from the original value
               if (flags.c || (a > BCD_MAX)) begin
                  corr = corr | DAA_HIGH;
               end
               if (flags.h || (a[3:0] > DIGIT_MAX)) begin
                  corr = corr | DAA_LOW;
               end
               r = a + corr;
               f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0,
                     c: (flags.c || (a > BCD_MAX))};
            end else begin
               if (flags.c) begin
                  corr = corr | DAA_HIGH;
               end
               if (flags.h) begin
                  corr = corr | DAA_LOW;
               end
               r = a - corr;
               f = '{z: (r == 8'd0), n: 1'b1, h: 1'b0, c: flags.c};
            end
         end
         OP_CPL: begin
            r = ~a;
            f = '{z: flags.z, n: 1'b1, h: 1'b1, c: flags.c};
         end
         OP_SCF: f = '{z: flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
         OP_CCF: f = '{z: flags.z, n: 1'b0, h: 1'b0, c: ~flags.c};
         OP_RLC: begin
            r = {a[6:0], a[7]};
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
         end
         OP_RRC: begin
            r = {a[0], a[7:1]};
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
         end
         OP_RL: begin
            r = {a[6:0], flags.c};
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
         end
         OP_RR: begin
            r = {flags.c, a[7:1]};
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
         end
         OP_SLA: begin
            r = {a[6:0], 1'b0};
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
         end
         OP_SRA: begin
            r = {a[7], a[7:1]};
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
         end
         OP_SRL: begin
            r = {1'b0, a[7:1]};
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
         end
         OP_SWAP: begin
            r = {a[3:0], a[7:4]};
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         OP_BIT: f = '{z: ((a & mask) == 8'd0), n: 1'b0, h: 1'b1, c: flags.c};
         OP_RES: r = a & ~mask;
         OP_SET: r = a | mask;
         default: begin
            // unused codes: pass the register through, keep the flags
            r = a;
         end
      endcase

      flags_next      = f;
      rsp.result_byte = r;
      rsp.result_word = w;
      rsp.flag_z      = f.z;
      rsp.flag_n      = f.n;
      rsp.flag_h      = f.h;
      rsp.flag_c      = f.c;
   end

endmodule

/* design/cpu_alu_with_flags_unit.sv */
// A response becomes valid after its request passes the input register, then
// the result register. Throughput: one request per cycle while rsp_ready is high.
// The flag loop is one ALU pass: flags update as a request moves into the
// result register, so the next request sees them. Reset (synchronous, high)
// clears Z, N, H, C and empties both register stages.
// Depends on cawf_pkg and cawf_alu.
module cpu_alu_with_flags_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cawf_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cawf_pkg::rsp_type rsp_payload
);
   import cawf_pkg::*;

   // Input register stage
   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_req_ff;
   // Result register stage
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_rsp_ff;
   // Persistent flags
   flags_type flags_ff;
   flags_type flags_in;

   rsp_type   alu_rsp;
   flags_type alu_flags;
   logic      advance;

   cawf_alu u_alu (
      .req        (in_req_ff),
      .flags      (flags_ff),
      .rsp        (alu_rsp),
      .flags_next (alu_flags)
   );

   // Advance the held request into the result register when that slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   // Take a new request whenever the input register empties this cycle
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);
   // Commit flags only when the request they belong to advances
   assign flags_in     = advance ? alu_flags : flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   // Payload registers: load on handshake, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= req_payload;
      end
      if (advance) begin
         out_rsp_ff <= alu_rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

endmodule
